/* rtl/octave_value_noise_sampler_assert.svh */
// Assertion macros used by the sampler controller.
// They expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef OCTAVE_VALUE_NOISE_SAMPLER_ASSERT_SVH
`define OCTAVE_VALUE_NOISE_SAMPLER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define OVNS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define OVNS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OVNS_ASSERT(lbl, prop, msg)
`define OVNS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* rtl/ovns_pkg.sv */
`timescale 1ns / 1ps
package ovns_pkg;

  localparam int LATTICE_DEPTH   = 65536;
  localparam int MAX_OCTAVES     = 8;
  localparam int COS_TABLE_DEPTH = 256;

  localparam int LAT_AW   = $clog2(LATTICE_DEPTH);
  localparam int COS_BITS = $clog2(COS_TABLE_DEPTH);
  localparam int OCT_W    = $clog2(MAX_OCTAVES + 1);

  // Scaled coordinate and lattice cell widths.
  localparam int SX_W   = 24 + MAX_OCTAVES - 1;
  localparam int CELL_W = SX_W - 16;
  localparam int ADDR_W0 = CELL_W + 1 + 9 + 1;
  localparam int ADDR_W  = (ADDR_W0 > LAT_AW + 1) ? ADDR_W0 : LAT_AW + 1;

  // Smoothed sample (units 2^-19), blend, product and accumulator widths.
  localparam int SMP_W  = 21;
  localparam int BLD_W  = SMP_W + 1;
  localparam int MULW   = BLD_W + 18;
  localparam int PROD_W = SMP_W + 18;
  localparam int TOT_W  = PROD_W + $clog2(MAX_OCTAVES) + 1;

  localparam logic       OP_LOAD = 1'b0;
  localparam logic       OP_EVAL = 1'b1;

  localparam logic [2:0] CFG_PERSISTENCE = 3'd0;
  localparam logic [2:0] CFG_OCTAVES     = 3'd1;
  localparam logic [2:0] CFG_WIDTH       = 3'd2;
  localparam logic [2:0] CFG_HEIGHT      = 3'd3;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SETUP, ST_READ, ST_DRAIN, ST_SMOOTH,
    ST_BLEND0, ST_BLEND1, ST_BLEND2, ST_MUL, ST_ACC, ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    BL_X_LOW, BL_X_HIGH, BL_Y
  } blend_sel_t;

  typedef struct packed {
    logic             load;
    logic             capture;
    logic             setup;
    logic             rd_issue;
    logic             row_step;
    logic             smooth;
    logic             blend_en;
    blend_sel_t       blend_sel;
    logic             mul;
    logic             acc;
    logic             finish;
    logic [OCT_W-1:0] octave;
  } dp_cmd_t;

  typedef struct packed {
    logic [OCT_W-1:0] n_oct;
  } dp_status_t;

  typedef logic [16:0] weight_t;
  typedef weight_t wtab_t [COS_TABLE_DEPTH];

  // (1-cos(pi*num/D))/2 in Q16 from a Taylor series of 1-cos in Q30.
  function automatic weight_t half_versine(input logic [63:0] num);
    logic        [63:0] th;
    logic        [63:0] th2;
    logic        [63:0] term;
    logic signed [63:0] sum;
    logic        [63:0] r;
    th   = (PI_Q30 * num) / 64'(COS_TABLE_DEPTH);
    th2  = (th * th) >> 30;
    term = th2 >> 1;
    sum  = signed'(term);
    term = ((term * th2) >> 30) / 64'd12;
    sum  = sum - signed'(term);
    term = ((term * th2) >> 30) / 64'd30;
    sum  = sum + signed'(term);
    term = ((term * th2) >> 30) / 64'd56;
    sum  = sum - signed'(term);
    term = ((term * th2) >> 30) / 64'd90;
    sum  = sum + signed'(term);
    term = ((term * th2) >> 30) / 64'd132;
    sum  = sum - signed'(term);
    term = ((term * th2) >> 30) / 64'd182;
    sum  = sum + signed'(term);
    term = ((term * th2) >> 30) / 64'd240;
    sum  = sum - signed'(term);
    if (sum < 0) begin
      sum = '0;
    end
    r = (unsigned'(sum) + 64'd16384) >> 15;
    return r[16:0];
  endfunction

  function automatic wtab_t build_weight_rom();
    wtab_t t;
    for (int k = 0; k < COS_TABLE_DEPTH; k++) begin
      if (2 * k <= COS_TABLE_DEPTH) begin
        t[k] = half_versine(64'(k));
      end else begin
        t[k] = 17'd65536 - half_versine(64'(COS_TABLE_DEPTH - k));
      end
    end
    return t;
  endfunction

  localparam wtab_t WEIGHT_ROM = build_weight_rom();

endpackage

/* rtl/ovns_datapath.sv */
`timescale 1ns / 1ps
module ovns_datapath
  import ovns_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic [15:0]         in_lattice_addr,
  input  logic signed [15:0]  in_lattice_value,
  input  logic [23:0]         in_coord_x,
  input  logic [23:0]         in_coord_y,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  dp_cmd_t             cmd,
  output dp_status_t          status,
  output logic                out_valid,
  output logic signed [16:0]  out_noise_value,
  output logic                out_out_of_range
);

  logic [15:0]              pers_r;
  logic [3:0]               oct_cfg_r;
  logic [8:0]               gw_r;
  logic [8:0]               gh_r;
  logic [23:0]              cx_r;
  logic [23:0]              cy_r;
  logic [ADDR_W-1:0]        limit_r;
  logic [ADDR_W-1:0]        limit_nxt;
  weight_t                  wx_r;
  weight_t                  wy_r;
  logic [ADDR_W-1:0]        row_r;
  logic [ADDR_W-1:0]        addr_r;
  logic                     rd_vld_r;
  logic                     rd_oor_r;
  logic [15:0]              rd_data_r;
  logic signed [15:0]       win_r [16];
  logic signed [SMP_W-1:0]  s_r [4];
  logic signed [SMP_W-1:0]  smp_nxt [4];
  logic signed [SMP_W-1:0]  h1_r;
  logic signed [SMP_W-1:0]  h2_r;
  logic signed [SMP_W-1:0]  v_r;
  logic [16:0]              amp_r;
  logic [16:0]              amp_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [TOT_W-1:0]  total_r;
  logic                     oor_r;
  logic                     out_valid_r;
  logic signed [16:0]       out_noise_value_r;
  logic                     out_out_of_range_r;

  logic [15:0]              lattice_mem [LATTICE_DEPTH];

  logic [SX_W-1:0]          sx;
  logic [SX_W-1:0]          sy;
  logic [ADDR_W-1:0]        row_base;
  logic [17:0]              area;
  logic                     wr_ok;
  logic signed [SMP_W-1:0]  bl_a;
  logic signed [SMP_W-1:0]  bl_b;
  weight_t                  bl_w;
  logic signed [BLD_W-1:0]  bl_diff;
  logic signed [MULW-1:0]   bl_wide;
  logic signed [SMP_W-1:0]  bl_res;
  logic signed [TOT_W-1:0]  rnd;
  logic signed [16:0]       sat;

  assign cfg_ready = 1'b1;
  assign status.n_oct = (32'(oct_cfg_r) > MAX_OCTAVES) ? OCT_W'(MAX_OCTAVES) : OCT_W'(oct_cfg_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pers_r    <= 16'd32768;
      oct_cfg_r <= 4'd4;
      gw_r      <= 9'd256;
      gh_r      <= 9'd256;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PERSISTENCE: pers_r    <= cfg_data;
        CFG_OCTAVES:     oct_cfg_r <= cfg_data[3:0];
        CFG_WIDTH:       gw_r      <= cfg_data[8:0];
        CFG_HEIGHT:      gh_r      <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Setup of one octave: scaled cell, fractions and the address of the window corner.
  always_comb begin
    sx       = SX_W'(cx_r) << cmd.octave;
    sy       = SX_W'(cy_r) << cmd.octave;
    row_base = ADDR_W'(sy[SX_W-1:16]) * ADDR_W'(gw_r) + ADDR_W'(sx[SX_W-1:16]);
    area     = 18'(gw_r) * 18'(gh_r);
    limit_nxt = (32'(area) < LATTICE_DEPTH) ? ADDR_W'(area) : ADDR_W'(LATTICE_DEPTH);
    wr_ok    = 32'(in_lattice_addr) < LATTICE_DEPTH;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cx_r    <= in_coord_x;
      cy_r    <= in_coord_y;
      limit_r <= limit_nxt;
    end
    if (cmd.setup) begin
      wx_r   <= WEIGHT_ROM[sx[15 -: COS_BITS]];
      wy_r   <= WEIGHT_ROM[sy[15 -: COS_BITS]];
      row_r  <= row_base;
      addr_r <= row_base;
    end else if (cmd.rd_issue) begin
      if (cmd.row_step) begin
        row_r  <= row_r + ADDR_W'(gw_r);
        addr_r <= row_r + ADDR_W'(gw_r);
      end else begin
        addr_r <= addr_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && wr_ok) begin
      lattice_mem[LAT_AW'(in_lattice_addr)] <= in_lattice_value;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= lattice_mem[addr_r[LAT_AW-1:0]];
      rd_oor_r  <= addr_r >= limit_r;
    end
  end

  // The 4x4 window fills row by row; entry 4*dy+dx holds cell (X+dx, Y+dy).
  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      for (int j = 0; j < 15; j++) begin
        win_r[j] <= win_r[j+1];
      end
      win_r[15] <= rd_oor_r ? 16'sd0 : signed'(rd_data_r);
    end
  end

  function automatic logic signed [SMP_W-1:0] ext(input logic signed [15:0] v);
    return SMP_W'(v);
  endfunction

  always_comb begin
    for (int q = 0; q < 4; q++) begin
      smp_nxt[q] =
          ext(win_r[(q>>1)*4 + (q&1)]) + ext(win_r[(q>>1)*4 + (q&1) + 2])
        + ext(win_r[((q>>1)+2)*4 + (q&1)]) + ext(win_r[((q>>1)+2)*4 + (q&1) + 2])
        + ((ext(win_r[((q>>1)+1)*4 + (q&1)]) + ext(win_r[((q>>1)+1)*4 + (q&1) + 2])
          + ext(win_r[(q>>1)*4 + (q&1) + 1]) + ext(win_r[((q>>1)+2)*4 + (q&1) + 1])) <<< 1)
        + (ext(win_r[((q>>1)+1)*4 + (q&1) + 1]) <<< 2);
    end
  end

  // Shared blend: a + (b-a)*w, rounded half up at 2^-16.
  always_comb begin
    case (cmd.blend_sel)
      BL_X_LOW:  begin bl_a = s_r[0]; bl_b = s_r[1]; bl_w = wx_r; end
      BL_X_HIGH: begin bl_a = s_r[2]; bl_b = s_r[3]; bl_w = wx_r; end
      default:   begin bl_a = h1_r;   bl_b = h2_r;   bl_w = wy_r; end
    endcase
    bl_diff = BLD_W'(bl_b) - BLD_W'(bl_a);
    bl_wide = (MULW'(bl_a) <<< 16) + MULW'(bl_diff) * MULW'(signed'({1'b0, bl_w}))
              + MULW'(32'sd32768);
    bl_res  = SMP_W'(bl_wide >>> 16);
  end

  assign amp_nxt = 17'((34'(amp_r) * 34'(pers_r) + 34'd32768) >> 16);

  always_ff @(posedge clk) begin
    if (cmd.smooth) begin
      for (int q = 0; q < 4; q++) begin
        s_r[q] <= smp_nxt[q];
      end
    end
    if (cmd.blend_en) begin
      case (cmd.blend_sel)
        BL_X_LOW:  h1_r <= bl_res;
        BL_X_HIGH: h2_r <= bl_res;
        default:   v_r  <= bl_res;
      endcase
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(v_r) * PROD_W'(signed'({1'b0, amp_r}));
    end
  end

  always_comb begin
    rnd = (total_r + (TOT_W'(1) <<< 19)) >>> 20;
    if (rnd > TOT_W'(65535)) begin
      sat = 17'sd65535;
    end else if (rnd < -TOT_W'(65536)) begin
      sat = -17'sd65536;
    end else begin
      sat = 17'(rnd);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      amp_r       <= 17'd65536;
      total_r     <= '0;
      oor_r       <= 1'b0;
    end else begin
      rd_vld_r    <= cmd.rd_issue;
      out_valid_r <= cmd.finish;
      if (cmd.capture) begin
        amp_r   <= 17'd65536;
        total_r <= '0;
        oor_r   <= 1'b0;
      end else begin
        if (cmd.mul) begin
          amp_r <= amp_nxt;
        end
        if (cmd.acc) begin
          total_r <= total_r + TOT_W'(prod_r);
        end
        if (rd_vld_r && rd_oor_r) begin
          oor_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_noise_value_r  <= sat;
      out_out_of_range_r <= oor_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_noise_value  = out_noise_value_r;
  assign out_out_of_range = out_out_of_range_r;

endmodule

/* rtl/ovns_ctrl.sv */
`timescale 1ns / 1ps
`include "octave_value_noise_sampler_assert.svh"
module ovns_ctrl
  import ovns_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       in_opcode,
  input  dp_status_t status,
  output logic       busy,
  output dp_cmd_t    cmd
);

  state_t           state_r;
  state_t           state_nxt;
  logic [3:0]       rd_cnt_r;
  logic [OCT_W-1:0] oct_cnt_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start && in_opcode == OP_EVAL) begin
          state_nxt = (status.n_oct == '0) ? ST_DONE : ST_SETUP;
        end
      end
      ST_SETUP:  state_nxt = ST_READ;
      ST_READ:   if (rd_cnt_r == 4'd15) state_nxt = ST_DRAIN;
      ST_DRAIN:  state_nxt = ST_SMOOTH;
      ST_SMOOTH: state_nxt = ST_BLEND0;
      ST_BLEND0: state_nxt = ST_BLEND1;
      ST_BLEND1: state_nxt = ST_BLEND2;
      ST_BLEND2: state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_ACC;
      ST_ACC:    state_nxt = (oct_cnt_r == status.n_oct - OCT_W'(1)) ? ST_DONE : ST_SETUP;
      ST_DONE:   state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.octave = oct_cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        cmd.load    = start && in_opcode == OP_LOAD;
        cmd.capture = start && in_opcode == OP_EVAL;
      end
      ST_SETUP: cmd.setup = 1'b1;
      ST_READ: begin
        cmd.rd_issue = 1'b1;
        cmd.row_step = rd_cnt_r[1:0] == 2'd3;
      end
      ST_SMOOTH: cmd.smooth = 1'b1;
      ST_BLEND0: begin cmd.blend_en = 1'b1; cmd.blend_sel = BL_X_LOW;  end
      ST_BLEND1: begin cmd.blend_en = 1'b1; cmd.blend_sel = BL_X_HIGH; end
      ST_BLEND2: begin cmd.blend_en = 1'b1; cmd.blend_sel = BL_Y;      end
      ST_MUL:    cmd.mul    = 1'b1;
      ST_ACC:    cmd.acc    = 1'b1;
      ST_DONE:   cmd.finish = 1'b1;
      default: ;
    endcase
  end

  assign busy = state_r != ST_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rd_cnt_r  <= '0;
      oct_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_SETUP) begin
        rd_cnt_r <= '0;
      end else if (state_r == ST_READ) begin
        rd_cnt_r <= rd_cnt_r + 4'd1;
      end
      if (state_r == ST_IDLE) begin
        oct_cnt_r <= '0;
      end else if (state_r == ST_ACC) begin
        oct_cnt_r <= oct_cnt_r + OCT_W'(1);
      end
    end
  end

  `OVNS_ASSERT(a_read_burst, (state_r == ST_READ && rd_cnt_r == 4'd15) |=> state_r == ST_DRAIN, "read burst did not end after sixteen words")
  `OVNS_ASSERT(a_eval_leaves_idle, (state_r == ST_IDLE && start && in_opcode == OP_EVAL) |=> busy, "evaluation transaction not taken up")
  `OVNS_ASSERT(a_octave_bound, (state_r == ST_SETUP) |-> (oct_cnt_r < status.n_oct), "octave index beyond the octave count")
  `OVNS_ASSERT(a_one_result, cmd.finish |=> !cmd.finish && state_r == ST_IDLE, "result strobe not a single cycle")

endmodule

/* rtl/octave_value_noise_sampler.sv */
`timescale 1ns / 1ps
// Two-dimensional value noise summed over octaves, cosine interpolated.
// Input channel: a transaction is taken at a clock edge with start high and
// busy low. Opcode load writes one signed Q1.15 lattice word in that cycle and
// produces no result. Opcode evaluate runs a query at the Q8.16 point
// (in_coord_x, in_coord_y) and raises busy until its result is out.
// Each octave reads a 4x4 window of lattice words through the single read
// port of the lattice memory, one word a cycle, then smooths, blends and
// accumulates; a query runs one such pass for each octave, with the octave
// count capped at 8.
// The result appears on out_noise_value and out_out_of_range for one cycle
// with out_valid high; the receiver cannot stall it.
// Configuration writes (persistence, octave count, grid width and height)
// are taken whenever cfg_valid is high and are meant to be made while idle.
// Reset returns the controller to idle and the configuration registers to
// their defaults; the lattice contents are undefined until loaded.
module octave_value_noise_sampler
  import ovns_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_opcode,
  input  logic [15:0]        in_lattice_addr,
  input  logic signed [15:0] in_lattice_value,
  input  logic [23:0]        in_coord_x,
  input  logic [23:0]        in_coord_y,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               out_valid,
  output logic signed [16:0] out_noise_value,
  output logic               out_out_of_range
);

  dp_cmd_t    cmd;
  dp_status_t status;

  ovns_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_opcode (in_opcode),
    .status    (status),
    .busy      (busy),
    .cmd       (cmd)
  );

  ovns_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_lattice_addr  (in_lattice_addr),
    .in_lattice_value (in_lattice_value),
    .in_coord_x       (in_coord_x),
    .in_coord_y       (in_coord_y),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (out_valid),
    .out_noise_value  (out_noise_value),
    .out_out_of_range (out_out_of_range)
  );

endmodule
